>>> src/sceg_pkg.sv
// Shared types and constants for the softmax cross-entropy gradient block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package sceg_pkg;

  localparam int NUM_CLASSES         = 10;
  localparam int FEATURES_PER_SAMPLE = 512;

  localparam int VAL_W  = 32;
  localparam int CLS_W  = 6;
  localparam int ROW_W  = 12;
  localparam int PCNT_W = 7;
  localparam int FCNT_W = 13;
  localparam int CE_AW  = $clog2(NUM_CLASSES);
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 16;

  localparam logic OP_PRED     = 1'b0;
  localparam logic OP_FEAT     = 1'b1;
  localparam logic KIND_BIAS   = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  localparam logic signed [VAL_W:0]   Q_ONE   = 33'sh0_0001_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] sample_value;
    logic [CLS_W-1:0]        true_label;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] gradient;
    logic                    gradient_kind;
    logic [ROW_W-1:0]        input_index;
    logic [CLS_W-1:0]        class_index;
    logic                    last_of_run;
    logic                    order_error;
  } out_item_t;

  // Controller to datapath, one slot per cycle while the datapath advances
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic             err;
    logic             wr;
    logic             load_feat;
    logic             onehot;
    logic [CLS_W-1:0] cls;
    logic [ROW_W-1:0] row;
    logic             last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic advance;
  } stat_t;

endpackage

>>> src/sceg_dp.sv
// Datapath: class error memory, error subtract, multiply and round/saturate pipeline,
// and the output register. Depends on sceg_pkg.
`timescale 1ns / 1ps

module sceg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sceg_pkg::in_item_t  in_payload_i,
  input  sceg_pkg::cmd_t      cmd_i,
  output sceg_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sceg_pkg::out_item_t out_payload_o
);

  logic                              adv;
  logic signed [sceg_pkg::VAL_W:0]   diff;
  logic signed [sceg_pkg::VAL_W-1:0] e_val;
  logic [sceg_pkg::CE_AW-1:0]        addr;

  logic signed [sceg_pkg::VAL_W-1:0] ce_mem [sceg_pkg::NUM_CLASSES];
  logic signed [sceg_pkg::VAL_W-1:0] feat_r;

  logic                              s1_vld_r;
  sceg_pkg::cmd_t                    s1_cmd_r;
  logic signed [sceg_pkg::VAL_W-1:0] rd_r;
  logic signed [sceg_pkg::VAL_W-1:0] bias1_r;

  logic                               s2_vld_r;
  sceg_pkg::cmd_t                     s2_cmd_r;
  logic signed [sceg_pkg::PROD_W-1:0] prod_r;
  logic signed [sceg_pkg::VAL_W-1:0]  bias2_r;

  logic signed [sceg_pkg::PROD_W-1:0] rnd;
  logic signed [sceg_pkg::PROD_W-sceg_pkg::FRAC_W-1:0] shf;
  logic signed [sceg_pkg::VAL_W-1:0]  wsat;
  logic signed [sceg_pkg::VAL_W-1:0]  grad;
  logic [sceg_pkg::PROD_W-sceg_pkg::FRAC_W-sceg_pkg::VAL_W:0] top_bits;

  logic                out_valid_r;
  sceg_pkg::out_item_t out_r;

  assign adv            = !out_valid_r || !out_stall_i;
  assign stat_o.advance = adv;
  assign addr           = cmd_i.cls[sceg_pkg::CE_AW-1:0];

  always_comb begin
    diff = {in_payload_i.sample_value[sceg_pkg::VAL_W-1], in_payload_i.sample_value}
         - (cmd_i.onehot ? sceg_pkg::Q_ONE : '0);
    if (diff[sceg_pkg::VAL_W] != diff[sceg_pkg::VAL_W-1]) begin
      e_val = diff[sceg_pkg::VAL_W] ? sceg_pkg::VAL_MIN : sceg_pkg::VAL_MAX;
    end else begin
      e_val = diff[sceg_pkg::VAL_W-1:0];
    end
  end

  // round half up, drop fraction, saturate; pick zero on error, the error for bias
  always_comb begin
    rnd      = prod_r + sceg_pkg::PROD_W'(64'sd32768);
    shf      = rnd[sceg_pkg::PROD_W-1:sceg_pkg::FRAC_W];
    top_bits = shf[sceg_pkg::PROD_W-sceg_pkg::FRAC_W-1:sceg_pkg::VAL_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      wsat = shf[sceg_pkg::VAL_W-1:0];
    end else begin
      wsat = shf[sceg_pkg::PROD_W-sceg_pkg::FRAC_W-1] ? sceg_pkg::VAL_MIN : sceg_pkg::VAL_MAX;
    end
    if (s2_cmd_r.err) begin
      grad = '0;
    end else if (s2_cmd_r.kind == sceg_pkg::KIND_BIAS) begin
      grad = bias2_r;
    end else begin
      grad = wsat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.valid && cmd_i.wr) begin
      ce_mem[addr] <= e_val;
    end
    if (cmd_i.load_feat) begin
      feat_r <= in_payload_i.sample_value;
    end
    if (adv) begin
      rd_r     <= ce_mem[addr];
      bias1_r  <= e_val;
      s1_cmd_r <= cmd_i;
      prod_r   <= rd_r * feat_r;
      bias2_r  <= bias1_r;
      s2_cmd_r <= s1_cmd_r;
      out_r.gradient      <= grad;
      out_r.gradient_kind <= s2_cmd_r.kind;
      out_r.input_index   <= s2_cmd_r.row;
      out_r.class_index   <= s2_cmd_r.cls;
      out_r.last_of_run   <= s2_cmd_r.last;
      out_r.order_error   <= s2_cmd_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= cmd_i.valid;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
    end
  end

  assign out_valid_o   = out_valid_r;
  assign out_payload_o = out_r;

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_vld_r))
    else $error("result appeared without a pipeline slot");

  a_wr_only_bias: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.valid && cmd_i.wr) |-> (!cmd_i.err && cmd_i.kind == sceg_pkg::KIND_BIAS))
    else $error("class error written by a non-bias slot");

endmodule

>>> src/sceg_ctrl.sv
// Controller: sample sequencing, prediction and feature counters, order checks,
// and per-class slot issue. Depends on sceg_pkg.
`timescale 1ns / 1ps

module sceg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sceg_pkg::in_item_t in_payload_i,
  input  sceg_pkg::stat_t    stat_i,
  output sceg_pkg::cmd_t     cmd_o
);

  typedef enum logic [0:0] {S_IDLE, S_RUN} state_t;

  state_t                      state_r, state_nxt;
  logic [sceg_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [sceg_pkg::FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [sceg_pkg::CLS_W-1:0]  k_r, k_nxt;
  logic                        accept;
  logic                        loaded;
  logic                        k_last;

  assign loaded = (pcnt_r == sceg_pkg::PCNT_W'(sceg_pkg::NUM_CLASSES));
  assign k_last = (k_r == sceg_pkg::CLS_W'(sceg_pkg::NUM_CLASSES - 1));
  assign in_stall_o = !(state_r == S_IDLE && stat_i.advance);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_nxt = state_r;
    pcnt_nxt  = pcnt_r;
    fcnt_nxt  = fcnt_r;
    k_nxt     = k_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_payload_i.operation == sceg_pkg::OP_PRED) begin
            cmd_o.valid = 1'b1;
            cmd_o.kind  = sceg_pkg::KIND_BIAS;
            cmd_o.last  = 1'b1;
            if (!loaded) begin
              cmd_o.wr     = 1'b1;
              cmd_o.cls    = pcnt_r[sceg_pkg::CLS_W-1:0];
              cmd_o.onehot = ({1'b0, in_payload_i.true_label} == pcnt_r);
              pcnt_nxt     = pcnt_r + 1'b1;
            end else begin
              cmd_o.err = 1'b1;
            end
          end else begin
            if (!loaded) begin
              cmd_o.valid = 1'b1;
              cmd_o.kind  = sceg_pkg::KIND_WEIGHT;
              cmd_o.err   = 1'b1;
              cmd_o.last  = 1'b1;
            end else begin
              cmd_o.load_feat = 1'b1;
              k_nxt           = '0;
              state_nxt       = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        if (stat_i.advance) begin
          cmd_o.valid = 1'b1;
          cmd_o.kind  = sceg_pkg::KIND_WEIGHT;
          cmd_o.cls   = k_r;
          cmd_o.row   = fcnt_r[sceg_pkg::ROW_W-1:0];
          cmd_o.last  = k_last;
          k_nxt       = k_r + 1'b1;
          if (k_last) begin
            state_nxt = S_IDLE;
            if (fcnt_r == sceg_pkg::FCNT_W'(sceg_pkg::FEATURES_PER_SAMPLE - 1)) begin
              fcnt_nxt = '0;
              pcnt_nxt = '0;
            end else begin
              fcnt_nxt = fcnt_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r  <= '0;
      fcnt_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pcnt_r  <= pcnt_nxt;
      fcnt_r  <= fcnt_nxt;
      k_r     <= k_nxt;
    end
  end

  a_run_needs_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> loaded)
    else $error("feature run without a full set of class errors");

  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= sceg_pkg::PCNT_W'(sceg_pkg::NUM_CLASSES))
    else $error("prediction count past class count");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && k_last && stat_i.advance) |=> (state_r == S_IDLE))
    else $error("feature run did not end after the last class");

endmodule

>>> src/softmax_cross_entropy_gradient_top.sv
// Top level of the softmax cross-entropy gradient block: controller plus datapath.
// Depends on sceg_pkg, sceg_ctrl and sceg_dp.
//
//   port group   direction  payload type          role
//   in_*         input      sceg_pkg::in_item_t   predictions and features
//   out_*        output     sceg_pkg::out_item_t  bias and weight gradients
//
// A prediction item or an out-of-order item yields one result.
// A feature item yields NUM_CLASSES results: one multiplier and the single read
// port of the class error memory serve one class per cycle unless the output stalls.
// Results pass s1, s2 and out. Reset clears state, counters and pipeline valids only.
// out_stall freezes the whole pipeline; in_stall is high during a feature run.
`timescale 1ns / 1ps

module softmax_cross_entropy_gradient_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sceg_pkg::in_item_t  in_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output sceg_pkg::out_item_t out_payload
);

  sceg_pkg::cmd_t  cmd;
  sceg_pkg::stat_t stat;

  sceg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_payload_i (in_payload),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  sceg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_payload_i  (in_payload),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_payload_o (out_payload)
  );

endmodule

>>> tb/tb_softmax_cross_entropy_gradient_top.sv
`timescale 1ns / 1ps
// Self-checking bench for softmax_cross_entropy_gradient_top: a directed table, then random
// items, each result checked against its table entry or a Q16.16 predictor.
// Depends on sceg_pkg and the block RTL; reads no files.

module tb_softmax_cross_entropy_gradient_top;

  typedef struct packed {
    sceg_pkg::in_item_t  item;
    logic                typed;
    sceg_pkg::out_item_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sceg_pkg::in_item_t  in_payload = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sceg_pkg::out_item_t out_payload;

  sceg_pkg::out_item_t               expected_grads[$];
  sceg_pkg::out_item_t               want;
  logic signed [sceg_pkg::VAL_W-1:0] class_err_m[sceg_pkg::NUM_CLASSES];
  int                                pred_loaded = 0;
  int                                feat_done = 0;
  int                                mismatch_count = 0;
  int                                rx_wait = 0;
  bit                                rx_quiet = 1'b0;
  bit                                tx_quiet = 1'b0;
  dir_row_t                          dir_tab[22];

  softmax_cross_entropy_gradient_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sceg_pkg::in_item_t mk_in(logic op, logic [sceg_pkg::VAL_W-1:0] val,
                                               logic [sceg_pkg::CLS_W-1:0] lbl);
    sceg_pkg::in_item_t it;
    it.operation    = op;
    it.sample_value = val;
    it.true_label   = lbl;
    return it;
  endfunction

  function automatic sceg_pkg::out_item_t mk_out(logic [sceg_pkg::VAL_W-1:0] grad, logic kind,
                                                 logic [sceg_pkg::ROW_W-1:0] row,
                                                 logic [sceg_pkg::CLS_W-1:0] cls,
                                                 logic last, logic err);
    sceg_pkg::out_item_t r;
    r.gradient      = grad;
    r.gradient_kind = kind;
    r.input_index   = row;
    r.class_index   = cls;
    r.last_of_run   = last;
    r.order_error   = err;
    return r;
  endfunction

  function automatic logic signed [sceg_pkg::VAL_W-1:0] sat_q(
      logic signed [sceg_pkg::PROD_W-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return sceg_pkg::VAL_MAX;
    if (v < 64'shFFFF_FFFF_8000_0000) return sceg_pkg::VAL_MIN;
    return v[sceg_pkg::VAL_W-1:0];
  endfunction

  // updates the model state; queues the results unless the caller supplies them
  task automatic predict_gradients(input sceg_pkg::in_item_t it, input bit keep);
    logic signed [sceg_pkg::PROD_W-1:0] val;
    logic signed [sceg_pkg::PROD_W-1:0] ce;
    logic signed [sceg_pkg::PROD_W-1:0] wide;
    sceg_pkg::out_item_t                r;
    val = {{sceg_pkg::VAL_W{it.sample_value[sceg_pkg::VAL_W-1]}}, it.sample_value};
    r = '0;
    r.last_of_run = 1'b1;
    if (it.operation == sceg_pkg::OP_PRED) begin
      r.gradient_kind = sceg_pkg::KIND_BIAS;
      if (pred_loaded >= sceg_pkg::NUM_CLASSES) begin
        r.order_error = 1'b1;
      end else begin
        wide = val - ((it.true_label == pred_loaded) ? 64'sh1_0000 : 64'sh0);
        class_err_m[pred_loaded] = sat_q(wide);
        r.gradient    = class_err_m[pred_loaded];
        r.class_index = sceg_pkg::CLS_W'(pred_loaded);
        pred_loaded++;
      end
      if (keep) expected_grads.push_back(r);
    end else if (pred_loaded < sceg_pkg::NUM_CLASSES) begin
      r.gradient_kind = sceg_pkg::KIND_WEIGHT;
      r.order_error   = 1'b1;
      if (keep) expected_grads.push_back(r);
    end else begin
      for (int k = 0; k < sceg_pkg::NUM_CLASSES; k++) begin
        ce   = {{sceg_pkg::VAL_W{class_err_m[k][sceg_pkg::VAL_W-1]}}, class_err_m[k]};
        wide = ce * val;
        wide = (wide + 64'sd32768) >>> sceg_pkg::FRAC_W;
        r.gradient      = sat_q(wide);
        r.gradient_kind = sceg_pkg::KIND_WEIGHT;
        r.input_index   = sceg_pkg::ROW_W'(feat_done);
        r.class_index   = sceg_pkg::CLS_W'(k);
        r.last_of_run   = (k == sceg_pkg::NUM_CLASSES - 1);
        r.order_error   = 1'b0;
        if (keep) expected_grads.push_back(r);
      end
      feat_done++;
      if (feat_done >= sceg_pkg::FEATURES_PER_SAMPLE) begin
        feat_done   = 0;
        pred_loaded = 0;
      end
    end
  endtask

  task automatic send_item(input sceg_pkg::in_item_t it, input bit keep);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_gradients(it, keep);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_grads.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: grad=%h kind=%0d row=%0d cls=%0d last=%0d err=%0d",
                     out_payload.gradient, out_payload.gradient_kind, out_payload.input_index,
                     out_payload.class_index, out_payload.last_of_run, out_payload.order_error);
        end else begin
          want = expected_grads.pop_front();
          if (out_payload.gradient !== want.gradient ||
              out_payload.gradient_kind !== want.gradient_kind ||
              out_payload.input_index !== want.input_index ||
              out_payload.class_index !== want.class_index ||
              out_payload.last_of_run !== want.last_of_run ||
              out_payload.order_error !== want.order_error) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: grad=%h kind=%0d row=%0d cls=%0d last=%0d err=%0d",
                       want.gradient, want.gradient_kind, want.input_index,
                       want.class_index, want.last_of_run, want.order_error);
              $display("         got: grad=%h kind=%0d row=%0d cls=%0d last=%0d err=%0d",
                       out_payload.gradient, out_payload.gradient_kind, out_payload.input_index,
                       out_payload.class_index, out_payload.last_of_run, out_payload.order_error);
            end
          end
        end
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
        out_stall <= (rx_wait != 0);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_stall <= (rx_wait != 0);
      end
    end
  end

  initial begin
    sceg_pkg::in_item_t it;
    dir_tab[0]  = '{mk_in(sceg_pkg::OP_FEAT, 32'h0001_0000, 6'd63), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_WEIGHT, 12'd0, 6'd0, 1'b1, 1'b1)};
    dir_tab[1]  = '{mk_in(sceg_pkg::OP_PRED, 32'h0000_8000, 6'd0), 1'b1,
                    mk_out(32'hFFFF_8000, sceg_pkg::KIND_BIAS, 12'd0, 6'd0, 1'b1, 1'b0)};
    dir_tab[2]  = '{mk_in(sceg_pkg::OP_FEAT, 32'hFFFF_FFFF, 6'd0), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_WEIGHT, 12'd0, 6'd0, 1'b1, 1'b1)};
    dir_tab[3]  = '{mk_in(sceg_pkg::OP_PRED, sceg_pkg::VAL_MIN, 6'd1), 1'b1,
                    mk_out(sceg_pkg::VAL_MIN, sceg_pkg::KIND_BIAS, 12'd0, 6'd1, 1'b1, 1'b0)};
    dir_tab[4]  = '{mk_in(sceg_pkg::OP_PRED, sceg_pkg::VAL_MAX, 6'd1), 1'b1,
                    mk_out(sceg_pkg::VAL_MAX, sceg_pkg::KIND_BIAS, 12'd0, 6'd2, 1'b1, 1'b0)};
    dir_tab[5]  = '{mk_in(sceg_pkg::OP_PRED, 32'h0001_0000, 6'd3), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_BIAS, 12'd0, 6'd3, 1'b1, 1'b0)};
    // labels past the last class match nothing
    dir_tab[6]  = '{mk_in(sceg_pkg::OP_PRED, 32'h0000_4000, 6'd63), 1'b1,
                    mk_out(32'h0000_4000, sceg_pkg::KIND_BIAS, 12'd0, 6'd4, 1'b1, 1'b0)};
    dir_tab[7]  = '{mk_in(sceg_pkg::OP_PRED, 32'hFFFF_FFFF, 6'd10), 1'b1,
                    mk_out(32'hFFFF_FFFF, sceg_pkg::KIND_BIAS, 12'd0, 6'd5, 1'b1, 1'b0)};
    dir_tab[8]  = '{mk_in(sceg_pkg::OP_PRED, 32'h7FFF_0000, 6'd6), 1'b1,
                    mk_out(32'h7FFE_0000, sceg_pkg::KIND_BIAS, 12'd0, 6'd6, 1'b1, 1'b0)};
    dir_tab[9]  = '{mk_in(sceg_pkg::OP_PRED, 32'h0, 6'd62), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_BIAS, 12'd0, 6'd7, 1'b1, 1'b0)};
    dir_tab[10] = '{mk_in(sceg_pkg::OP_PRED, 32'h0001_0000, 6'd9), 1'b1,
                    mk_out(32'h0001_0000, sceg_pkg::KIND_BIAS, 12'd0, 6'd8, 1'b1, 1'b0)};
    dir_tab[11] = '{mk_in(sceg_pkg::OP_PRED, 32'h0000_1234, 6'd9), 1'b1,
                    mk_out(32'hFFFF_1234, sceg_pkg::KIND_BIAS, 12'd0, 6'd9, 1'b1, 1'b0)};
    dir_tab[12] = '{mk_in(sceg_pkg::OP_PRED, 32'h0, 6'd0), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_BIAS, 12'd0, 6'd0, 1'b1, 1'b1)};
    dir_tab[13] = '{mk_in(sceg_pkg::OP_FEAT, 32'h0, 6'd63), 1'b0, '0};
    dir_tab[14] = '{mk_in(sceg_pkg::OP_FEAT, sceg_pkg::VAL_MAX, 6'd0), 1'b0, '0};
    dir_tab[15] = '{mk_in(sceg_pkg::OP_FEAT, sceg_pkg::VAL_MIN, 6'd21), 1'b0, '0};
    dir_tab[16] = '{mk_in(sceg_pkg::OP_FEAT, 32'h0001_0000, 6'd42), 1'b0, '0};
    dir_tab[17] = '{mk_in(sceg_pkg::OP_FEAT, 32'hFFFF_0000, 6'd5), 1'b0, '0};
    dir_tab[18] = '{mk_in(sceg_pkg::OP_FEAT, 32'h0000_0001, 6'd0), 1'b0, '0};
    dir_tab[19] = '{mk_in(sceg_pkg::OP_FEAT, 32'hFFFF_FFFF, 6'd63), 1'b0, '0};
    dir_tab[20] = '{mk_in(sceg_pkg::OP_PRED, sceg_pkg::VAL_MAX, 6'd63), 1'b1,
                    mk_out(32'h0, sceg_pkg::KIND_BIAS, 12'd0, 6'd0, 1'b1, 1'b1)};
    dir_tab[21] = '{mk_in(sceg_pkg::OP_FEAT, 32'h0000_8000, 6'd0), 1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item, !dir_tab[i].typed);
      if (dir_tab[i].typed) expected_grads.push_back(dir_tab[i].res);
    end

    // mostly well-formed order with some out-of-order items
    for (int n = 0; n < 280; n++) begin
      if (pred_loaded < sceg_pkg::NUM_CLASSES)
        it.operation = ($urandom_range(0, 19) == 0) ? sceg_pkg::OP_FEAT : sceg_pkg::OP_PRED;
      else
        it.operation = ($urandom_range(0, 39) == 0) ? sceg_pkg::OP_PRED : sceg_pkg::OP_FEAT;
      it.true_label = ($urandom_range(0, 3) == 0) ?
                      sceg_pkg::CLS_W'($urandom_range(0, 63)) :
                      sceg_pkg::CLS_W'($urandom_range(0, sceg_pkg::NUM_CLASSES - 1));
      case ($urandom_range(0, 7))
        0, 1, 2, 3: begin
          if (it.operation == sceg_pkg::OP_PRED)
            it.sample_value = $urandom_range(0, 32'h0001_0000);
          else
            it.sample_value = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        end
        4, 5: it.sample_value = $urandom;
        6: begin
          case ($urandom_range(0, 3))
            0: it.sample_value = sceg_pkg::VAL_MIN;
            1: it.sample_value = sceg_pkg::VAL_MAX;
            2: it.sample_value = '0;
            default: it.sample_value = 32'h0001_0000;
          endcase
        end
        default: it.sample_value = $urandom_range(0, 255);
      endcase
      send_item(it, 1'b1);
    end
    in_valid <= 1'b0;

    while (expected_grads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
